// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the qpc RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/qpc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpc_pkg
// Types, constants and helpers for the quadrature position counter.
// ---------------------------------------------------------------------------
package qpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int RAW_W           = 16;
    localparam int DET_W           = 14;
    localparam int STEP_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int DETENT_SHIFT    = 2;

    localparam logic signed [RAW_W-1:0] MIN_COUNT_RST  = 16'sd0;
    localparam logic signed [RAW_W-1:0] MAX_COUNT_RST  = 16'sd127;
    localparam logic [STEP_W-1:0]       CLICK_STEP_RST = 8'd10;

    typedef logic [1:0] t_phase;

    localparam t_phase PH_00 = 2'd0;
    localparam t_phase PH_01 = 2'd1;
    localparam t_phase PH_10 = 2'd2;
    localparam t_phase PH_11 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_STEP = 2'd2;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic button_n;
    } t_sample;

    typedef struct packed {
        logic signed [RAW_W-1:0] min_count;
        logic signed [RAW_W-1:0] max_count;
        logic [STEP_W-1:0]       click_step;
    } t_cfg;

    typedef struct packed {
        logic signed [DET_W-1:0] detent_position;
        logic signed [RAW_W-1:0] raw_count;
        logic                    moved;
        logic                    forward;
    } t_result;

    // Gray sequence 0-1-3-2-0 is the forward direction.
    function automatic logic is_forward(input t_phase from_ph, input t_phase to_ph);
        logic fwd;
        fwd = 1'b0;
        case (from_ph)
            PH_00:   fwd = (to_ph == PH_01);
            PH_01:   fwd = (to_ph == PH_11);
            PH_11:   fwd = (to_ph == PH_10);
            PH_10:   fwd = (to_ph == PH_00);
            default: fwd = 1'b0;
        endcase
        return fwd;
    endfunction

endpackage

// ===== rtl/qpc_update.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpc_update
// Phase decode, step, clamp and detent scaling; holds phase and count.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qpc_update #(
    parameter int COUNT_WIDTH = qpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  qpc_pkg::t_sample i_sample,
    input  qpc_pkg::t_cfg    i_cfg,
    output qpc_pkg::t_result o_result
);
    import qpc_pkg::*;

    localparam int SUM_W = ((COUNT_WIDTH > RAW_W) ? COUNT_WIDTH : RAW_W) + 2;

    localparam logic signed [SUM_W-1:0] CMAX =
        {{(SUM_W-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

    t_phase                         r_last_phase;
    logic signed [COUNT_WIDTH-1:0]  r_count;
    t_phase                         n_last_phase;
    logic signed [COUNT_WIDTH-1:0]  n_count;

    t_phase                  phase;
    logic                    moved;
    logic                    fwd;
    logic signed [SUM_W-1:0] step;
    logic signed [SUM_W-1:0] cur;
    logic signed [SUM_W-1:0] lim_lo;
    logic signed [SUM_W-1:0] lim_hi;
    logic signed [SUM_W-1:0] sum0;
    logic signed [SUM_W-1:0] sum1;
    logic signed [SUM_W-1:0] sum2;
    logic signed [SUM_W-1:0] sum3;
    logic signed [SUM_W-1:0] sum4;
    logic signed [RAW_W-1:0] raw;
    logic signed [SUM_W-1:0] raw_adj;

    always_comb begin
        phase  = {i_sample.pin_b, i_sample.pin_a};
        moved  = (phase != r_last_phase);
        fwd    = moved && is_forward(r_last_phase, phase);
        step   = !i_sample.button_n ? signed'({{(SUM_W-STEP_W){1'b0}}, i_cfg.click_step})
                                    : signed'(SUM_W'(1));
        cur    = signed'({{(SUM_W-COUNT_WIDTH){r_count[COUNT_WIDTH-1]}}, r_count});
        lim_lo = signed'({{(SUM_W-RAW_W){i_cfg.min_count[RAW_W-1]}}, i_cfg.min_count});
        lim_hi = signed'({{(SUM_W-RAW_W){i_cfg.max_count[RAW_W-1]}}, i_cfg.max_count});

        sum0 = !moved ? cur : (fwd ? cur + step : cur - step);
        sum1 = (sum0 < lim_lo) ? lim_lo : sum0;
        sum2 = (sum1 > lim_hi) ? lim_hi : sum1;
        sum3 = (sum2 < CMIN) ? CMIN : sum2;
        sum4 = (sum3 > CMAX) ? CMAX : sum3;

        raw     = sum4[RAW_W-1:0];
        raw_adj = sum4[SUM_W-1] ? sum4 + signed'(SUM_W'(3)) : sum4;

        o_result.detent_position = raw_adj[DET_W+DETENT_SHIFT-1:DETENT_SHIFT];
        o_result.raw_count       = raw;
        o_result.moved           = moved;
        o_result.forward         = fwd;

        n_last_phase = i_fire ? phase : r_last_phase;
        n_count      = i_fire ? sum4[COUNT_WIDTH-1:0] : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= PH_00;
            r_count      <= '0;
        end else begin
            r_last_phase <= n_last_phase;
            r_count      <= n_count;
        end
    end

    `ASSERT_CLK(a_state_holds, !i_fire |=> $stable(r_last_phase) && $stable(r_count), "state changed without a request")
    `ASSERT_CLK(a_phase_tracks, i_fire |=> r_last_phase == $past(phase), "stored phase does not follow the sample")
    `ASSERT_NEVER(a_fwd_without_move, i_fire && o_result.forward && !o_result.moved, "forward flagged without a phase change")

endmodule

// ===== rtl/qpc_out_buf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpc_out_buf
// Result register with one skid entry for the output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qpc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qpc_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output qpc_pkg::t_result o_data,
    output logic             o_full
);
    import qpc_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    `ASSERT_NEVER(a_skid_without_out, r_skid_valid && !r_out_valid, "skid entry held with empty result register")
    `ASSERT_NEVER(a_push_when_full, i_push && r_skid_valid, "request pushed into a full buffer")

endmodule

// ===== rtl/quadrature_position_counter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_position_counter_top
// Quadrature encoder decoder with clamped raw count and detent position.
// ---------------------------------------------------------------------------
// One result per request, one request per clock when the output is not
// stalled. A request is captured in an input register, then decoded and
// counted, and its result is registered in the output register. A skid entry
// behind the output register lets one more request finish while the output
// is stalled; o_in_stall rises only when that entry is occupied. Limit writes
// take effect from the next request on; the user must write configuration
// only while no request is in flight. The block itself does not enforce this.

module quadrature_position_counter_top #(
    parameter int COUNT_WIDTH = qpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_pin_a,
    input  logic                                  i_pin_b,
    input  logic                                  i_button_n,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [qpc_pkg::DET_W-1:0]      o_detent_position,
    output logic signed [qpc_pkg::RAW_W-1:0]      o_raw_count,
    output logic                                  o_moved,
    output logic                                  o_forward,
    input  logic                                  i_cfg_we,
    input  logic [qpc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [qpc_pkg::RAW_W-1:0]             i_cfg_data
);
    import qpc_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_sample r_in;
    logic    in_fire;
    logic    advance;
    logic    buf_full;
    t_result result;
    t_result out_data;

    assign o_in_stall = buf_full;
    assign in_fire    = i_in_valid && !buf_full;
    assign advance    = r_in_valid && !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_count  <= MIN_COUNT_RST;
            r_cfg.max_count  <= MAX_COUNT_RST;
            r_cfg.click_step <= CLICK_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_COUNT:  r_cfg.min_count  <= signed'(i_cfg_data);
                CFG_MAX_COUNT:  r_cfg.max_count  <= signed'(i_cfg_data);
                CFG_CLICK_STEP: r_cfg.click_step <= i_cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.pin_a    <= i_pin_a;
            r_in.pin_b    <= i_pin_b;
            r_in.button_n <= i_button_n;
        end
    end

    qpc_update #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_sample (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    qpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .o_full  (buf_full)
    );

    assign o_detent_position = out_data.detent_position;
    assign o_raw_count       = out_data.raw_count;
    assign o_moved           = out_data.moved;
    assign o_forward         = out_data.forward;

endmodule

// ===== test/qpc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpc_checker
// Watches the sample, result and register ports of the quadrature position
// counter. It keeps its own limits, click step, last phase and raw count,
// predicts the result of every accepted request and compares each result
// field, in request order, against the oldest prediction.
// ---------------------------------------------------------------------------
module qpc_checker #(
    parameter int COUNT_WIDTH = qpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_pin_a,
    input  logic                             i_pin_b,
    input  logic                             i_button_n,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [qpc_pkg::DET_W-1:0] i_detent_position,
    input  logic signed [qpc_pkg::RAW_W-1:0] i_raw_count,
    input  logic                             i_moved,
    input  logic                             i_forward,
    input  logic                             i_cfg_we,
    input  logic [qpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qpc_pkg::RAW_W-1:0]        i_cfg_data,
    output int                               o_error_count,
    output int                               o_pending
);
    import qpc_pkg::*;

    t_result                 expected_positions[$];
    logic signed [RAW_W-1:0] lim_lo;
    logic signed [RAW_W-1:0] lim_hi;
    logic [STEP_W-1:0]       click_size;
    t_phase                  prev_phase;
    longint                  position;
    logic                    sample_taken;
    logic                    result_taken;

    assign sample_taken = i_in_valid && !i_in_stall;
    assign result_taken = i_out_valid && !i_out_stall;

    function automatic logic is_gray_step(input t_phase from_ph, input t_phase to_ph);
        case ({from_ph, to_ph})
            {PH_00, PH_01}, {PH_01, PH_11}, {PH_11, PH_10}, {PH_10, PH_00}: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_result advance_counter(input logic pa, input logic pb,
                                                input logic btn_n);
        t_result r;
        t_phase  ph;
        longint  sum;
        longint  delta;
        longint  top_val;
        ph        = {pb, pa};
        top_val   = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
        r.moved   = (ph != prev_phase);
        r.forward = r.moved && is_gray_step(prev_phase, ph);
        sum       = position;
        if (r.moved) begin
            delta = btn_n ? longint'(1) : longint'(click_size);
            sum   = r.forward ? sum + delta : sum - delta;
        end
        // lower limit first, so crossed limits settle on the upper one
        if (sum < lim_lo) sum = lim_lo;
        if (sum > lim_hi) sum = lim_hi;
        if (sum < -top_val - 1) sum = -top_val - 1;
        if (sum > top_val) sum = top_val;
        position          = sum;
        prev_phase        = ph;
        r.raw_count       = RAW_W'(sum);
        r.detent_position = DET_W'(sum / (1 << DETENT_SHIFT));
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        o_error_count++;
    endtask

    task automatic check_result(input t_result want);
        if (i_detent_position !== want.detent_position) begin
            report_mismatch($sformatf("detent_position expected %0d, got %0d",
                                      want.detent_position, i_detent_position));
        end
        if (i_raw_count !== want.raw_count) begin
            report_mismatch($sformatf("raw_count expected %0d, got %0d",
                                      want.raw_count, i_raw_count));
        end
        if (i_moved !== want.moved) begin
            report_mismatch($sformatf("moved expected %0b, got %0b", want.moved, i_moved));
        end
        if (i_forward !== want.forward) begin
            report_mismatch($sformatf("forward expected %0b, got %0b",
                                      want.forward, i_forward));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_lo     = MIN_COUNT_RST;
            lim_hi     = MAX_COUNT_RST;
            click_size = CLICK_STEP_RST;
            prev_phase = PH_00;
            position   = 0;
            expected_positions.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_COUNT:  lim_lo = i_cfg_data;
                    CFG_MAX_COUNT:  lim_hi = i_cfg_data;
                    CFG_CLICK_STEP: click_size = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (sample_taken) begin
                expected_positions.push_back(advance_counter(i_pin_a, i_pin_b, i_button_n));
            end
            if (result_taken) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    check_result(expected_positions.pop_front());
                end
            end
            o_pending <= o_pending + int'(sample_taken) - int'(result_taken);
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives encoder samples and register writes into the quadrature position
// counter: a directed pass over clamps, double jumps, crossed and collapsed
// limits and a zero click step, then random encoder walks with noise under
// many limit settings, with random idling on both sides and a long output
// hold-off. The checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
module tb_top;
    import qpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_SEGMENTS   = 16;
    localparam int SEGMENT_LEN  = 50;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     pin_a     = 1'b0;
    logic                     pin_b     = 1'b0;
    logic                     button_n  = 1'b1;
    logic                     out_valid;
    logic                     out_stall = 1'b1;
    logic signed [DET_W-1:0]  detent_position;
    logic signed [RAW_W-1:0]  raw_count;
    logic                     moved;
    logic                     forward;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_MIN_COUNT;
    logic [RAW_W-1:0]         cfg_data  = '0;
    int                       error_count;
    int                       pending;

    int                       send_idle_pct = 28;
    int                       recv_idle_pct = 78;
    logic                     hold_kick     = 1'b0;
    int                       hold_left     = 0;
    int                       idle_cycles   = 0;
    t_phase                   enc_phase     = PH_00;

    quadrature_position_counter_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_pin_a           (pin_a),
        .i_pin_b           (pin_b),
        .i_button_n        (button_n),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_detent_position (detent_position),
        .o_raw_count       (raw_count),
        .o_moved           (moved),
        .o_forward         (forward),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    qpc_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_pin_a           (pin_a),
        .i_pin_b           (pin_b),
        .i_button_n        (button_n),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_detent_position (detent_position),
        .i_raw_count       (raw_count),
        .i_moved           (moved),
        .i_forward         (forward),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_error_count     (error_count),
        .o_pending         (pending)
    );

    always #5 clk = ~clk;

    // result side: random stall, or a long hold-off when kicked
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b1;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_kick) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_phase step_phase(input t_phase ph, input logic fwd);
        case (ph)
            PH_00:   return fwd ? PH_01 : PH_10;
            PH_01:   return fwd ? PH_11 : PH_00;
            PH_11:   return fwd ? PH_10 : PH_01;
            default: return fwd ? PH_00 : PH_11;
        endcase
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic send_sample(input t_phase ph, input logic btn_n);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_a     <= ph[0];
        pin_b     <= ph[1];
        button_n  <= btn_n;
        enc_phase = ph;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input int lo, input int hi, input int st);
        wait_results_done();
        write_reg(CFG_MIN_COUNT, RAW_W'(lo));
        write_reg(CFG_MAX_COUNT, RAW_W'(hi));
        write_reg(CFG_CLICK_STEP, RAW_W'(st));
        write_reg(CFG_UNUSED, RAW_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        int lo;
        int hi;
        int st;
        case ($urandom_range(0, 4))
            0: begin
                lo = -32768;
                hi = 32767;
            end
            1: begin
                lo = 0 - int'($urandom_range(0, 60));
                hi = int'($urandom_range(0, 60));
            end
            2: begin
                lo = int'($urandom_range(0, 40));
                hi = 0 - int'($urandom_range(0, 40));
            end
            3: begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = lo + int'($urandom_range(0, 200));
                if (hi > 32767) hi = 32767;
            end
            default: begin
                lo = -32768 + int'($urandom_range(0, 100));
                hi = 32767 - int'($urandom_range(0, 100));
            end
        endcase
        case ($urandom_range(0, 3))
            0:       st = 0;
            1:       st = 255;
            2:       st = 1;
            default: st = int'($urandom_range(0, 255));
        endcase
        configure(lo, hi, st);
    endtask

    // mostly clean encoder runs, some noise with random jumps
    task automatic run_segment(input int n_items);
        int     left;
        int     run_len;
        logic   dir;
        logic   btn_n;
        logic   noisy;
        t_phase ph;
        left = n_items;
        while (left > 0) begin
            run_len = $urandom_range(1, 12);
            dir     = $urandom_range(0, 1);
            btn_n   = ($urandom_range(0, 3) != 0);
            noisy   = ($urandom_range(0, 99) < 15);
            for (int k = 0; k < run_len && left > 0; k++) begin
                if (noisy) begin
                    ph    = t_phase'($urandom_range(0, 3));
                    btn_n = $urandom_range(0, 1);
                end else if ($urandom_range(0, 9) == 0) begin
                    ph = enc_phase;
                end else begin
                    ph = step_phase(enc_phase, dir);
                end
                send_sample(ph, btn_n);
                left--;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits 0..127, step 10
        send_sample(PH_00, 1'b1);
        send_sample(PH_10, 1'b1);
        send_sample(PH_00, 1'b1);
        send_sample(PH_01, 1'b1);
        send_sample(PH_11, 1'b1);
        send_sample(PH_10, 1'b1);
        send_sample(PH_01, 1'b1);
        send_sample(PH_10, 1'b1);
        send_sample(PH_10, 1'b1);
        send_sample(PH_00, 1'b0);
        send_sample(PH_01, 1'b0);
        send_sample(PH_10, 1'b0);
        send_sample(PH_01, 1'b0);

        configure(-8, 20, 255);
        send_sample(PH_11, 1'b0);
        send_sample(PH_01, 1'b0);

        // new limits pull the count in without a phase change
        configure(5, 9, 0);
        send_sample(PH_01, 1'b1);
        send_sample(PH_11, 1'b0);

        // crossed limits
        configure(100, -100, 10);
        send_sample(PH_11, 1'b1);

        configure(-32768, -32768, 10);
        send_sample(PH_11, 1'b1);

        configure(-32768, 32767, 255);
        send_sample(PH_01, 1'b0);

        configure(32767, 32767, 255);
        send_sample(PH_01, 1'b1);

        configure(-32768, 32767, 255);
        send_sample(PH_11, 1'b0);
        send_sample(PH_01, 1'b1);

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            if (seg == 6) set_idle(78, 28);
            if (seg == 12) set_idle(0, 0);
            random_config();
            if (seg == 12) begin
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            run_segment(SEGMENT_LEN);
        end

        wait_results_done();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
